@@ design/set_assoc_lru_cache_filter_defines.svh @@
// Assertion macros shared by the cache filter RTL.
// Used by set_assoc_lru_cache_filter.sv; expects clk and rst_n in scope.
`ifndef SET_ASSOC_LRU_CACHE_FILTER_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_FILTER_DEFINES_SVH

// same-cycle implication
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/salc_pkg.sv @@
// Shared constants and types of the set-associative LRU cache filter.
// No dependencies.
`timescale 1ns / 1ps

package salc_pkg;

    localparam int NUM_SETS    = 2048;
    localparam int NUM_WAYS    = 16;
    localparam int BLOCK_BYTES = 64;

    localparam int ADDR_W  = 64;
    localparam int TID_W   = 16;
    localparam int STAMP_W = 64;
    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int TAG_W   = ADDR_W - OFF_W - SET_W;
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

    // request kinds on req_type
    localparam logic REQ_ACCESS     = 1'b0;
    localparam logic REQ_INVALIDATE = 1'b1;

    // one memory row holds a whole set
    typedef struct packed {
        logic [NUM_WAYS-1:0]               valid;
        logic [NUM_WAYS-1:0][TAG_W-1:0]    tag;
        logic [NUM_WAYS-1:0][STAMP_W-1:0]  stamp;
    } row_t;

    typedef struct packed {
        logic             rd;
        logic             wr;
        logic [SET_W-1:0] addr;
    } mem_req_t;

endpackage

@@ design/salc_row_mem.sv @@
// Set row memory with a clearing sweep after reset.
// Depends on salc_pkg.
`timescale 1ns / 1ps

module salc_row_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  salc_pkg::mem_req_t req,
    input  salc_pkg::row_t    wdata,
    output salc_pkg::row_t    rdata,
    output logic              ready
);
    import salc_pkg::*;

    row_t             mem [NUM_SETS];
    row_t             rdata_reg;
    logic             clr_busy_reg;
    logic [SET_W-1:0] clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == SET_W'(NUM_SETS - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_idx_reg] <= '0;
        else if (req.wr)
            mem[req.addr] <= wdata;
        if (req.rd)
            rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;
    assign ready = !clr_busy_reg;

endmodule

@@ design/set_assoc_lru_cache_filter.sv @@
// Set-associative cache filter with LRU replacement: top level.
// Channels: request (in_valid/in_ready: req_type, thread_id, address) and
// result (out_valid/out_ready), one result per request, in order.
// Each set is one row of a 2048-deep memory (valid, tag, stamp of all
// 16 ways), read once per request and written back when a request changes it.
// Path: accept -> memory read -> lookup -> result; a hit, an invalidate or a
// miss into an invalid way goes from the lookup straight to the result.
// A miss into a full set first scans the 16 stamps one way per cycle.
// No new request is taken until the result of the current one is loaded
// into the output register.
// After reset the memory is swept clear, one set per cycle, and in_ready
// stays low until the sweep ends.
// When the receiver stalls, the finished result waits in the output
// register; the next request is accepted and processed up to its own
// result, which then waits until the register frees.
// Depends on salc_pkg, salc_row_mem and set_assoc_lru_cache_filter_defines.svh.
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_filter_defines.svh"

module set_assoc_lru_cache_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic [salc_pkg::TID_W-1:0]       thread_id,
    input  logic [salc_pkg::ADDR_W-1:0]      address,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic                             miss_out,
    output logic [salc_pkg::TID_W-1:0]       miss_thread,
    output logic [salc_pkg::ADDR_W-1:0]      miss_address,
    output logic                             evict_valid,
    output logic [salc_pkg::ADDR_W-1:0]      evict_address,
    output logic                             invalidated
);
    import salc_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_LOOKUP = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_HIT   = 2'd1,
        ACT_FILL  = 2'd2,
        ACT_INVAL = 2'd3
    } act_t;

    state_t               state_reg, state_next;
    act_t                 act_reg, act_next;
    logic                 type_reg;
    logic [TID_W-1:0]     thread_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [STAMP_W-1:0]   counter_reg;
    row_t                 row_reg, row_next;
    logic [WAY_W-1:0]     way_reg, way_next;
    logic [WAY_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [STAMP_W-1:0]   best_stamp_reg, best_stamp_next;

    logic                 out_valid_reg;
    logic                 hit_reg, miss_reg, evict_reg, inval_reg;
    logic [TID_W-1:0]     miss_thread_reg;
    logic [ADDR_W-1:0]    miss_addr_reg, evict_addr_reg;

    mem_req_t             mem_req;
    row_t                 rd_row, wr_row;
    logic                 mem_ready;

    logic [TAG_W-1:0]     cur_tag;
    logic [SET_W-1:0]     cur_set;
    logic [NUM_WAYS-1:0]  match;
    logic [WAY_W-1:0]     match_way, inv_way;
    logic                 any_inv;
    logic                 out_free, accept, finish;

    salc_row_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .wdata (wr_row),
        .rdata (rd_row),
        .ready (mem_ready)
    );

    assign cur_tag  = addr_reg[ADDR_W-1 -: TAG_W];
    assign cur_set  = addr_reg[OFF_W +: SET_W];
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign finish   = (state_reg == ST_DONE) && out_free;

    // tag match and first invalid way over the row just read
    always_comb
    begin
        match_way = '0;
        inv_way   = '0;
        any_inv   = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
            match[w] = rd_row.valid[w] && (rd_row.tag[w] == cur_tag);
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
                match_way = WAY_W'(w);
            if (!rd_row.valid[w])
            begin
                inv_way = WAY_W'(w);
                any_inv = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        row_next        = row_reg;
        way_next        = way_reg;
        scan_idx_next   = scan_idx_reg;
        best_stamp_next = best_stamp_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (mem_ready)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                row_next   = rd_row;
                state_next = ST_DONE;
                if (type_reg == REQ_INVALIDATE)
                begin
                    act_next = (|match) ? ACT_INVAL : ACT_NONE;
                    way_next = match_way;
                end
                else if (|match)
                begin
                    act_next = ACT_HIT;
                    way_next = match_way;
                end
                else
                begin
                    act_next = ACT_FILL;
                    if (any_inv || NUM_WAYS == 1)
                        way_next = inv_way;
                    else
                    begin
                        // full set: look for the oldest stamp
                        way_next        = '0;
                        best_stamp_next = rd_row.stamp[0];
                        scan_idx_next   = WAY_W'(1);
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (row_reg.stamp[scan_idx_reg] < best_stamp_reg)
                begin
                    way_next        = scan_idx_reg;
                    best_stamp_next = row_reg.stamp[scan_idx_reg];
                end
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == WAY_W'(NUM_WAYS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // modified row written back at the end of the transaction
    always_comb
    begin
        wr_row = row_reg;
        unique case (act_reg)
            ACT_HIT:
                wr_row.stamp[way_reg] = counter_reg;
            ACT_FILL:
            begin
                wr_row.valid[way_reg] = 1'b1;
                wr_row.tag[way_reg]   = cur_tag;
                wr_row.stamp[way_reg] = counter_reg;
            end
            ACT_INVAL:
                wr_row.valid[way_reg] = 1'b0;
            default: wr_row = row_reg;
        endcase
    end

    always_comb
    begin
        mem_req.rd   = accept;
        mem_req.wr   = finish && (act_reg != ACT_NONE);
        mem_req.addr = accept ? address[OFF_W +: SET_W] : cur_set;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            act_reg       <= ACT_NONE;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            if (accept && (req_type == REQ_ACCESS))
                counter_reg <= counter_reg + 1'b1;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        way_reg        <= way_next;
        scan_idx_reg   <= scan_idx_next;
        best_stamp_reg <= best_stamp_next;
        if (accept)
        begin
            type_reg   <= req_type;
            thread_reg <= thread_id;
            addr_reg   <= address;
        end
        if (finish)
        begin
            hit_reg         <= (act_reg == ACT_HIT);
            miss_reg        <= (act_reg == ACT_FILL);
            inval_reg       <= (act_reg == ACT_INVAL);
            miss_thread_reg <= (act_reg == ACT_FILL) ? thread_reg : '0;
            miss_addr_reg   <= (act_reg == ACT_FILL) ? addr_reg : '0;
            evict_reg       <= (act_reg == ACT_FILL) && row_reg.valid[way_reg];
            evict_addr_reg  <= ((act_reg == ACT_FILL) && row_reg.valid[way_reg]) ?
                               {row_reg.tag[way_reg], cur_set, {OFF_W{1'b0}}} : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign miss_out      = miss_reg;
    assign miss_thread   = miss_thread_reg;
    assign miss_address  = miss_addr_reg;
    assign evict_valid   = evict_reg;
    assign evict_address = evict_addr_reg;
    assign invalidated   = inval_reg;

    `SALC_ASSERT_NOW(a_accept_after_clear, accept, mem_ready,
        "request accepted during clearing sweep")
    `SALC_ASSERT_NOW(a_one_outcome, out_valid_reg,
        $onehot0({hit_reg, miss_reg, inval_reg}), "conflicting result flags")
    `SALC_ASSERT_NOW(a_evict_on_miss, out_valid_reg && evict_reg, miss_reg,
        "eviction reported without a miss")
    `SALC_ASSERT_NEXT(a_result_after_write, mem_req.wr, out_valid_reg,
        "row written back without a result")

endmodule

@@ verif/set_assoc_lru_cache_filter_checker.sv @@
// Scoreboard for the set-associative LRU cache filter: watches both channels,
// predicts each result from its own copy of the cache state and compares.
// Depends on salc_pkg.
`timescale 1ns / 1ps

module set_assoc_lru_cache_filter_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          req_type,
    input  logic [salc_pkg::TID_W-1:0]    thread_id,
    input  logic [salc_pkg::ADDR_W-1:0]   address,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          hit,
    input  logic                          miss_out,
    input  logic [salc_pkg::TID_W-1:0]    miss_thread,
    input  logic [salc_pkg::ADDR_W-1:0]   miss_address,
    input  logic                          evict_valid,
    input  logic [salc_pkg::ADDR_W-1:0]   evict_address,
    input  logic                          invalidated,
    output int                            fail_count,
    output int                            accepted_count,
    output int                            pending_count
);
    import salc_pkg::*;

    typedef struct packed {
        logic              hit;
        logic              miss;
        logic [TID_W-1:0]  tid;
        logic [ADDR_W-1:0] maddr;
        logic              evict;
        logic [ADDR_W-1:0] eaddr;
        logic              inv;
    } lookup_result_t;

    // sparse shadow of the cache, indexed by set * NUM_WAYS + way
    bit               way_valid [int];
    logic [TAG_W-1:0] way_tag   [int];
    logic [63:0]      way_stamp [int];
    logic [63:0]      access_cnt;
    lookup_result_t   expected_results[$];

    function automatic bit is_valid(int idx);
        return way_valid.exists(idx) && way_valid[idx];
    endfunction

    function automatic lookup_result_t predict_lookup(logic kind, logic [TID_W-1:0] tid,
                                                      logic [ADDR_W-1:0] addr);
        lookup_result_t   r;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        int               base;
        int               found;
        int               victim;
        r       = '0;
        set_idx = addr[OFF_W +: SET_W];
        tag     = addr[ADDR_W-1 -: TAG_W];
        base    = int'(set_idx) * NUM_WAYS;
        found   = -1;
        for (int w = 0; w < NUM_WAYS; w++)
            if (found < 0 && is_valid(base + w) && way_tag[base + w] == tag)
                found = w;
        if (kind == REQ_INVALIDATE)
        begin
            if (found >= 0)
            begin
                way_valid[base + found] = 0;
                r.inv = 1'b1;
            end
            return r;
        end
        access_cnt = access_cnt + 1;
        if (found >= 0)
        begin
            way_stamp[base + found] = access_cnt;
            r.hit = 1'b1;
            return r;
        end
        r.miss  = 1'b1;
        r.tid   = tid;
        r.maddr = addr;
        victim  = -1;
        for (int w = 0; w < NUM_WAYS; w++)
            if (victim < 0 && !is_valid(base + w))
                victim = w;
        if (victim < 0)
        begin
            victim = 0;
            for (int w = 1; w < NUM_WAYS; w++)
                if (way_stamp[base + w] < way_stamp[base + victim])
                    victim = w;
            r.evict = 1'b1;
            r.eaddr = {way_tag[base + victim], set_idx, {OFF_W{1'b0}}};
        end
        way_valid[base + victim] = 1;
        way_tag[base + victim]   = tag;
        way_stamp[base + victim] = access_cnt;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t exp_r;
        lookup_result_t act_r;
        if (!rst_n)
        begin
            way_valid.delete();
            access_cnt = '0;
            expected_results.delete();
            fail_count     <= 0;
            accepted_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                act_r = '{hit, miss_out, miss_thread, miss_address,
                          evict_valid, evict_address, invalidated};
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result with nothing expected: %p", $realtime, act_r);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (act_r !== exp_r)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                     $realtime, exp_r, act_r);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_lookup(req_type, thread_id, address));
                accepted_count <= accepted_count + 1;
            end
            pending_count <= expected_results.size();
        end
    end

endmodule

@@ verif/set_assoc_lru_cache_filter_tb.sv @@
// Testbench top for the set-associative LRU cache filter: clock, reset,
// request stimulus, result back-pressure and verdict.
// Depends on salc_pkg, the filter RTL and set_assoc_lru_cache_filter_checker.
`timescale 1ns / 1ps

module set_assoc_lru_cache_filter_tb;
    import salc_pkg::*;

    localparam int   CYCLE_LIMIT    = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              req_type = REQ_ACCESS;
    logic [TID_W-1:0]  thread_id = '0;
    logic [ADDR_W-1:0] address = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              hit, miss_out, evict_valid, invalidated;
    logic [TID_W-1:0]  miss_thread;
    logic [ADDR_W-1:0] miss_address, evict_address;
    int                fail_count, accepted_count, pending_count;
    int                sent_count = 0;
    bit                long_hold = 0;
    int                cycle_count = 0;

    logic [TAG_W-1:0]  tag_pool [20];
    logic [SET_W-1:0]  set_pool [5];

    always #1 clk = ~clk;

    set_assoc_lru_cache_filter dut (.*);
    set_assoc_lru_cache_filter_checker checker_i (.*);

    // drive one transaction, wait for its acceptance, then maybe idle
    task automatic send_request(logic kind, logic [TID_W-1:0] tid, logic [ADDR_W-1:0] addr,
                                bit allow_gap = 1);
        int gap;
        req_type  <= kind;
        thread_id <= tid;
        address   <= addr;
        in_valid  <= 1'b1;
        sent_count++;
        do @(negedge clk); while (accepted_count < sent_count);
        gap = 0;
        if (allow_gap && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic logic [ADDR_W-1:0] make_addr(logic [TAG_W-1:0] tag,
                                                     logic [SET_W-1:0] set_idx);
        return {tag, set_idx, OFF_W'($urandom)};
    endfunction

    // receiver: random ready bursts, plus one long hold-off on request
    initial
    begin
        int len;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                long_hold = 0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 2) != 0);
                len = ($urandom_range(0, 12) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 4);
                repeat (len) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("set_assoc_lru_cache_filter_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] addr;
        logic              kind;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, hit, invalidate present/absent, LRU eviction
        send_request(REQ_ACCESS, 16'h0000, '0);
        send_request(REQ_ACCESS, 16'hFFFF, '1);
        send_request(REQ_ACCESS, 16'h1234, '1);
        send_request(REQ_INVALIDATE, 16'hFFFF, '1);
        send_request(REQ_INVALIDATE, 16'h0000, '1);
        send_request(REQ_ACCESS, 16'hA5A5, 64'h0000_0000_0000_003F);
        for (int t = 0; t < 16; t++)
            send_request(REQ_ACCESS, 16'(t), {TAG_W'(t + 1), SET_W'(5), OFF_W'(0)});
        // refresh the oldest way so the second oldest gets evicted
        send_request(REQ_ACCESS, 16'h0101, {TAG_W'(1), SET_W'(5), OFF_W'(7)});
        send_request(REQ_ACCESS, 16'h0202, {TAG_W'(99), SET_W'(5), OFF_W'(0)});
        send_request(REQ_ACCESS, 16'h0303, {TAG_W'(100), SET_W'(5), OFF_W'(0)});

        for (int i = 0; i < 20; i++)
            tag_pool[i] = (i < 10) ? TAG_W'(i) : TAG_W'({$urandom, $urandom});
        set_pool = '{SET_W'(0), '1, SET_W'($urandom), SET_W'($urandom), SET_W'(5)};

        for (int i = 0; i < 500; i++)
        begin
            if (i == 150)
                long_hold = 1;
            if (i == 350)
            begin
                in_valid <= 1'b0;
                while (pending_count != 0) @(negedge clk);
            end
            if ($urandom_range(0, 9) == 0)
                addr = {$urandom, $urandom};
            else
                addr = make_addr(tag_pool[$urandom_range(0, 19)],
                                 set_pool[$urandom_range(0, 4)]);
            kind = ($urandom_range(0, 4) == 0) ? REQ_INVALIDATE : REQ_ACCESS;
            send_request(kind, TID_W'($urandom), addr, (i < 150 || i > 200));
        end
        in_valid <= 1'b0;

        while (pending_count != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("set_assoc_lru_cache_filter_tb: PASS");
        else
            $display("set_assoc_lru_cache_filter_tb: FAIL");
        $finish;
    end

endmodule
